/* rtl/core/ole_pkg.sv */
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and constants for the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int CAPACITY    = 256;
  localparam int SLOT_W      = $clog2(CAPACITY);
  localparam int LINK_W      = SLOT_W + 1;
  localparam int VALUE_WIDTH = 32;

  localparam logic [LINK_W-1:0] NULL_SLOT = LINK_W'(CAPACITY);

  localparam logic [3:0] MODE_INS_HEAD = 4'd0;
  localparam logic [3:0] MODE_INS_TAIL = 4'd1;
  localparam logic [3:0] MODE_INS_AT   = 4'd2;
  localparam logic [3:0] MODE_GET_AT   = 4'd3;
  localparam logic [3:0] MODE_RM_AT    = 4'd4;
  localparam logic [3:0] MODE_RM_VAL   = 4'd5;
  localparam logic [3:0] MODE_RM_HEAD  = 4'd6;
  localparam logic [3:0] MODE_RM_TAIL  = 4'd7;
  localparam logic [3:0] MODE_GET_HEAD = 4'd8;
  localparam logic [3:0] MODE_GET_TAIL = 4'd9;
  localparam logic [3:0] MODE_CUR_HEAD = 4'd10;
  localparam logic [3:0] MODE_CUR_TAIL = 4'd11;
  localparam logic [3:0] MODE_NEXT     = 4'd12;
  localparam logic [3:0] MODE_PREV     = 4'd13;
  localparam logic [3:0] MODE_CLEAR    = 4'd14;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] CUR_NONE   = 2'd0;
  localparam logic [1:0] CUR_BEFORE = 2'd1;
  localparam logic [1:0] CUR_AFTER  = 2'd2;
  localparam logic [1:0] CUR_ON     = 2'd3;

  typedef struct packed {
    logic [3:0]  mode;
    logic [8:0]  position;
    logic [31:0] object_value;
  } ole_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] object_out;
    logic [8:0]  element_count;
  } ole_out_t;

  // one node read from slot memory
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [LINK_W-1:0]      nxt;
    logic [LINK_W-1:0]      prv;
  } ole_node_t;

endpackage

/* rtl/core/ole_node_mem.sv */
// ----------------------------------------------------------------------------
// ole_node_mem
// Slot memory holding value, next and prev link for each node. Each link
// half can be written on its own; one registered read port.
// ----------------------------------------------------------------------------
module ole_node_mem import ole_pkg::*; (
  input  logic                   clk,
  input  logic                   wr_val,
  input  logic                   wr_nxt,
  input  logic                   wr_prv,
  input  logic [SLOT_W-1:0]      wr_addr,
  input  ole_node_t              wr_data,
  input  logic [SLOT_W-1:0]      rd_addr,
  output ole_node_t              rd_data
);

  logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];
  logic [LINK_W-1:0]      nxt_mem [CAPACITY];
  logic [LINK_W-1:0]      prv_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_val) val_mem[wr_addr] <= wr_data.value;
    if (wr_nxt) nxt_mem[wr_addr] <= wr_data.nxt;
    if (wr_prv) prv_mem[wr_addr] <= wr_data.prv;
    rd_data <= '{value: val_mem[rd_addr], nxt: nxt_mem[rd_addr], prv: prv_mem[rd_addr]};
  end

endmodule

/* rtl/core/ordered_list_engine_top.sv */
// ----------------------------------------------------------------------------
// ordered_list_engine_top
// Bounded doubly linked list of handles with a free slot stack.
// ----------------------------------------------------------------------------
// One command is worked at a time, and one result item is produced for each.
// Clear, cursor starts and early misses go straight from dispatch to the
// result; get head/tail reads the end node, and insert or remove at head/tail
// splices through states S_W1, S_W2 and S_W3. A position command walks the
// links from the nearer end, one hop at a time through the single read port
// of the node memory; remove by value walks from the head. Link updates of a
// splice are written one per cycle. The result waits in an output register
// while the next item is taken.
// ----------------------------------------------------------------------------
module ordered_list_engine_top import ole_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ole_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ole_out_t out_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_WALK  = 4'd2;  // issue read of cur_r
  localparam logic [3:0] S_WWAIT = 4'd3;  // read data arrives
  localparam logic [3:0] S_RD    = 4'd4;  // read of target node arrives
  localparam logic [3:0] S_TAKE  = 4'd5;  // free stack read arrives
  localparam logic [3:0] S_W1    = 4'd6;
  localparam logic [3:0] S_W2    = 4'd7;
  localparam logic [3:0] S_W3    = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_CWAIT = 4'd10; // cursor read arrives

  logic [3:0]             state_r, state_nxt;
  ole_in_t                cmd_r, cmd_nxt;
  logic [LINK_W-1:0]      head_r, head_nxt, tail_r, tail_nxt;
  logic [LINK_W-1:0]      free_top_r, free_top_nxt, fresh_r, fresh_nxt;
  logic [8:0]             count_r, count_nxt;
  logic [LINK_W-1:0]      cslot_r, cslot_nxt;
  logic [1:0]             ckind_r, ckind_nxt;
  logic [LINK_W-1:0]      cur_r, cur_nxt;     // walk pointer / target slot
  logic [8:0]             idx_r, idx_nxt;
  logic                   back_r, back_nxt;
  logic [LINK_W-1:0]      p_r, p_nxt, x_r, x_nxt, n_r, n_nxt;
  logic                   ins_r, ins_nxt;     // splice in vs out
  logic [1:0]             status_r, status_nxt;
  logic [31:0]            obj_r, obj_nxt;
  logic                   out_valid_r, out_valid_nxt;
  ole_out_t               out_r, out_nxt;

  logic                   wr_val, wr_nxt, wr_prv;
  logic [SLOT_W-1:0]      wr_addr, rd_addr;
  ole_node_t              wr_data, rd_data;

  logic [SLOT_W-1:0]      fs_mem [CAPACITY];
  logic                   fs_we;
  logic [SLOT_W-1:0]      fs_waddr, fs_raddr, fs_wdata, fs_rdata;

  ole_node_mem u_mem (
    .clk(clk), .wr_val(wr_val), .wr_nxt(wr_nxt), .wr_prv(wr_prv),
    .wr_addr(wr_addr), .wr_data(wr_data), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (fs_we) fs_mem[fs_waddr] <= fs_wdata;
    fs_rdata <= fs_mem[fs_raddr];
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  logic [3:0] m;
  assign m = cmd_r.mode;
  logic [VALUE_WIDTH-1:0] vin;
  assign vin = cmd_r.object_value[VALUE_WIDTH-1:0];

  always_comb begin
    state_nxt = state_r; cmd_nxt = cmd_r;
    head_nxt = head_r; tail_nxt = tail_r;
    free_top_nxt = free_top_r; fresh_nxt = fresh_r; count_nxt = count_r;
    cslot_nxt = cslot_r; ckind_nxt = ckind_r;
    cur_nxt = cur_r; idx_nxt = idx_r; back_nxt = back_r;
    p_nxt = p_r; x_nxt = x_r; n_nxt = n_r; ins_nxt = ins_r;
    status_nxt = status_r; obj_nxt = obj_r;
    out_valid_nxt = out_valid_r; out_nxt = out_r;
    wr_val = 1'b0; wr_nxt = 1'b0; wr_prv = 1'b0;
    wr_addr = '0; wr_data = '0; rd_addr = cur_r[SLOT_W-1:0];
    fs_we = 1'b0; fs_waddr = free_top_r[SLOT_W-1:0]; fs_wdata = '0;
    fs_raddr = SLOT_W'(free_top_r - 1'b1);

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_data;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        status_nxt = ST_OK; obj_nxt = '0; ins_nxt = 1'b0;
        p_nxt = NULL_SLOT; x_nxt = NULL_SLOT;
        state_nxt = S_DONE;
        case (m)
          MODE_INS_HEAD, MODE_INS_TAIL, MODE_INS_AT: begin
            ins_nxt = 1'b1;
            if (count_r >= 9'(CAPACITY)) status_nxt = ST_FULL;
            else if (m == MODE_INS_HEAD) begin
              x_nxt = head_r; state_nxt = S_TAKE;
            end else if (m == MODE_INS_TAIL || cmd_r.position == count_r) begin
              p_nxt = tail_r; state_nxt = S_TAKE;
            end else if (cmd_r.position > count_r) status_nxt = ST_MISS;
            else state_nxt = S_WALK;
            // start walk
            if (cmd_r.position <= (count_r >> 1)) begin
              cur_nxt = head_r; idx_nxt = '0; back_nxt = 1'b0;
            end else begin
              cur_nxt = tail_r; idx_nxt = count_r - 1'b1; back_nxt = 1'b1;
            end
          end
          MODE_GET_AT, MODE_RM_AT: begin
            if (cmd_r.position >= count_r) status_nxt = ST_MISS;
            else state_nxt = S_WALK;
            if (cmd_r.position <= (count_r >> 1)) begin
              cur_nxt = head_r; idx_nxt = '0; back_nxt = 1'b0;
            end else begin
              cur_nxt = tail_r; idx_nxt = count_r - 1'b1; back_nxt = 1'b1;
            end
          end
          MODE_RM_VAL: begin
            cur_nxt = head_r; idx_nxt = '0; back_nxt = 1'b0;
            if (count_r == '0) status_nxt = ST_MISS;
            else state_nxt = S_WALK;
          end
          MODE_RM_HEAD, MODE_GET_HEAD, MODE_RM_TAIL, MODE_GET_TAIL: begin
            cur_nxt = (m == MODE_RM_HEAD || m == MODE_GET_HEAD) ? head_r : tail_r;
            rd_addr = cur_nxt[SLOT_W-1:0];
            if (count_r == '0) status_nxt = ST_MISS;
            else state_nxt = S_RD;
          end
          MODE_CUR_HEAD, MODE_CUR_TAIL: begin
            if (count_r == '0) status_nxt = ST_MISS;
            else begin
              ckind_nxt = (m == MODE_CUR_HEAD) ? CUR_BEFORE : CUR_AFTER;
              cslot_nxt = NULL_SLOT;
            end
          end
          MODE_NEXT, MODE_PREV: begin
            rd_addr = cslot_r[SLOT_W-1:0];
            if (count_r == '0 || ckind_r == CUR_NONE ||
                (m == MODE_NEXT && ckind_r == CUR_AFTER) ||
                (m == MODE_PREV && ckind_r == CUR_BEFORE)) begin
              ckind_nxt = CUR_NONE; cslot_nxt = NULL_SLOT; status_nxt = ST_MISS;
            end else if (ckind_r == CUR_ON) state_nxt = S_CWAIT;
            else begin
              cur_nxt = (m == MODE_NEXT) ? head_r : tail_r;
              rd_addr = cur_nxt[SLOT_W-1:0];
              ckind_nxt = CUR_ON; cslot_nxt = cur_nxt;
              state_nxt = S_RD;
            end
          end
          MODE_CLEAR: begin
            free_top_nxt = '0; fresh_nxt = '0; head_nxt = NULL_SLOT;
            tail_nxt = NULL_SLOT; count_nxt = '0; cslot_nxt = NULL_SLOT;
            ckind_nxt = CUR_NONE;
          end
          default: ;
        endcase
      end

      S_CWAIT: begin
        cur_nxt = (m == MODE_NEXT) ? rd_data.nxt : rd_data.prv;
        rd_addr = cur_nxt[SLOT_W-1:0];
        if (cur_nxt >= NULL_SLOT) begin
          ckind_nxt = CUR_NONE; cslot_nxt = NULL_SLOT; status_nxt = ST_MISS;
          state_nxt = S_DONE;
        end else begin
          cslot_nxt = cur_nxt; state_nxt = S_RD;
        end
      end

      S_WALK: begin
        // cur_r is a valid slot; issue its read
        if (m != MODE_RM_VAL && idx_r == cmd_r.position) state_nxt = S_RD;
        else state_nxt = S_WWAIT;
      end

      S_WWAIT: begin
        state_nxt = S_WALK;
        if (m == MODE_RM_VAL) begin
          if (rd_data.value == vin) begin
            obj_nxt = 32'(vin); p_nxt = rd_data.prv; x_nxt = rd_data.nxt;
            state_nxt = S_W1;
          end else begin
            cur_nxt = rd_data.nxt; idx_nxt = idx_r + 1'b1;
            if (idx_nxt >= count_r || cur_nxt >= NULL_SLOT) begin
              status_nxt = ST_MISS; state_nxt = S_DONE;
            end
          end
        end else if (back_r) begin
          cur_nxt = rd_data.prv; idx_nxt = idx_r - 1'b1;
        end else begin
          cur_nxt = rd_data.nxt; idx_nxt = idx_r + 1'b1;
        end
      end

      S_RD: begin
        // rd_data is node cur_r
        if (ins_r) begin
          x_nxt = cur_r; p_nxt = rd_data.prv; state_nxt = S_TAKE;
        end else begin
          obj_nxt = 32'(rd_data.value);
          p_nxt = rd_data.prv; x_nxt = rd_data.nxt;
          if (m == MODE_RM_AT || m == MODE_RM_HEAD || m == MODE_RM_TAIL)
            state_nxt = S_W1;
          else state_nxt = S_DONE;
        end
      end

      S_TAKE: begin
        // fs_rdata valid here: read was addressed by free_top-1 last cycle
        if (free_top_r != '0) begin
          n_nxt = LINK_W'(fs_rdata); free_top_nxt = free_top_r - 1'b1;
        end else begin
          n_nxt = fresh_r; fresh_nxt = fresh_r + 1'b1;
        end
        state_nxt = S_W1;
      end

      S_W1: begin
        if (ins_r) begin
          wr_val = 1'b1; wr_nxt = 1'b1; wr_prv = 1'b1;
          wr_addr = n_r[SLOT_W-1:0];
          wr_data.value = vin; wr_data.nxt = x_r; wr_data.prv = p_r;
          count_nxt = count_r + 1'b1;
        end else begin
          // splice out cur_r: free it and fix count/cursor
          fs_we = 1'b1; fs_wdata = cur_r[SLOT_W-1:0];
          free_top_nxt = free_top_r + 1'b1;
          count_nxt = count_r - 1'b1;
          if (ckind_r == CUR_ON && cslot_r == cur_r) begin
            ckind_nxt = CUR_NONE; cslot_nxt = NULL_SLOT;
          end
        end
        state_nxt = S_W2;
      end

      S_W2: begin
        // predecessor's next link
        if (p_r >= NULL_SLOT) head_nxt = ins_r ? n_r : x_r;
        else begin
          wr_nxt = 1'b1; wr_addr = p_r[SLOT_W-1:0];
          wr_data.nxt = ins_r ? n_r : x_r;
        end
        state_nxt = S_W3;
      end

      S_W3: begin
        if (x_r >= NULL_SLOT) tail_nxt = ins_r ? n_r : p_r;
        else begin
          wr_prv = 1'b1; wr_addr = x_r[SLOT_W-1:0];
          wr_data.prv = ins_r ? n_r : p_r;
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt.status = status_r;
          out_nxt.object_out = (status_r == ST_OK) ? obj_r : '0;
          out_nxt.element_count = count_r;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= NULL_SLOT; tail_r <= NULL_SLOT;
      free_top_r <= '0; fresh_r <= '0; count_r <= '0;
      cslot_r <= NULL_SLOT; ckind_r <= CUR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt;
      free_top_r <= free_top_nxt; fresh_r <= fresh_nxt; count_r <= count_nxt;
      cslot_r <= cslot_nxt; ckind_r <= ckind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; cur_r <= cur_nxt; idx_r <= idx_nxt; back_r <= back_nxt;
    p_r <= p_nxt; x_r <= x_nxt; n_r <= n_nxt; ins_r <= ins_nxt;
    status_r <= status_nxt; obj_r <= obj_nxt; out_r <= out_nxt;
  end

endmodule
